// ===== rtl/stp_pkg.sv =====
// ----------------------------------------------------------------------------
// stp_pkg
// Shared constants and types for the stereo two-pole resonant filter.
// ----------------------------------------------------------------------------
package stp_pkg;

	// default parameter values
	localparam int SAMPLE_BITS_DEF    = 16;
	localparam int GAIN_FRAC_BITS_DEF = 16;

	// fixed number formats
	localparam int STAGE_BITS      = 32;  // stage value, signed, saturating
	localparam int STATE_FRAC_BITS = 8;   // fraction bits of a stage value
	localparam int FB_INT_BITS     = 7;   // integer bits of the feedback factor

	// the wide multiplier operand is taken in two chunks
	localparam int CHUNK_BITS = 24;
	localparam int OPND_BITS  = 2 * CHUNK_BITS;

	// configuration register indexes
	localparam int CFG_IDX_BITS = 3;
	localparam logic [CFG_IDX_BITS-1:0] REG_MODE        = 3'd0;
	localparam logic [CFG_IDX_BITS-1:0] REG_LEFT_GAIN   = 3'd1;
	localparam logic [CFG_IDX_BITS-1:0] REG_RIGHT_GAIN  = 3'd2;
	localparam logic [CFG_IDX_BITS-1:0] REG_LEFT_FB     = 3'd3;
	localparam logic [CFG_IDX_BITS-1:0] REG_RIGHT_FB    = 3'd4;

	// control of the shared multiply-accumulate unit
	typedef struct packed {
		logic issue;   // start a product this cycle
		logic hi;      // product uses the upper chunk, weight 2^CHUNK_BITS
		logic clear;   // zero the accumulator
	} mac_ctrl_t;

endpackage

// ===== rtl/stp_in_if.sv =====
// ----------------------------------------------------------------------------
// stp_in_if
// Stereo sample request channel: valid/ready with one left/right pair.
// ----------------------------------------------------------------------------
interface stp_in_if #(
	parameter int SAMPLE_BITS = stp_pkg::SAMPLE_BITS_DEF
) ();
	logic                          valid;
	logic                          ready;
	logic signed [SAMPLE_BITS-1:0] left_sample;
	logic signed [SAMPLE_BITS-1:0] right_sample;

	modport source (output valid, output left_sample, output right_sample, input ready);
	modport sink (input valid, input left_sample, input right_sample, output ready);
endinterface

// ===== rtl/stp_out_if.sv =====
// ----------------------------------------------------------------------------
// stp_out_if
// Filtered stereo result channel: valid/ready with one left/right pair.
// ----------------------------------------------------------------------------
interface stp_out_if #(
	parameter int SAMPLE_BITS = stp_pkg::SAMPLE_BITS_DEF
) ();
	logic                          valid;
	logic                          ready;
	logic signed [SAMPLE_BITS-1:0] left_out;
	logic signed [SAMPLE_BITS-1:0] right_out;

	modport source (output valid, output left_out, output right_out, input ready);
	modport sink (input valid, input left_out, input right_out, output ready);
endinterface

// ===== rtl/stereo_two_pole_resonant_filter_unit.sv =====
// ----------------------------------------------------------------------------
// stereo_two_pole_resonant_filter_unit
// Stereo resonant two-pole filter, low-pass or high-pass, fixed point.
// ----------------------------------------------------------------------------
// A stereo pair is filtered left channel first, then right, into the output
// register, and the next pair is accepted in the cycle after that result is
// loaded. Both channels share a single multiply-accumulate unit (an unsigned
// gain or feedback coefficient times a 25-bit signed chunk); each channel
// needs ten passes through it (feedback times stage difference, then the two
// smoothing sums, each wide operand split into two chunks), and a channel also
// passes through the drain of the last product from the product register and
// the saturation steps. Gains outside 0.01..0.99 are clamped when used;
// stage values saturate to 32 bits and outputs to the sample width.
// Configuration is taken at any cycle in which cfg_wr_en is high; writes to
// an unknown index are dropped.
// ----------------------------------------------------------------------------
module stereo_two_pole_resonant_filter_unit #(
	parameter int SAMPLE_BITS    = stp_pkg::SAMPLE_BITS_DEF,
	parameter int GAIN_FRAC_BITS = stp_pkg::GAIN_FRAC_BITS_DEF
) (
	input  logic                                                clk,
	input  logic                                                arst_n,
	input  logic                                                cfg_wr_en,
	input  logic [stp_pkg::CFG_IDX_BITS-1:0]                    cfg_index,
	input  logic [GAIN_FRAC_BITS+stp_pkg::FB_INT_BITS-1:0]      cfg_data,
	stp_in_if.sink                                              samples,
	stp_out_if.source                                           filtered
);
	localparam int GF        = GAIN_FRAC_BITS;
	localparam int FB_BITS   = GF + stp_pkg::FB_INT_BITS;
	localparam int COEF_BITS = FB_BITS;
	// g * inner stays below 2^(GF + STAGE_BITS + FB_INT_BITS + 1)
	localparam int ACC_BITS  = GF + stp_pkg::STAGE_BITS + stp_pkg::FB_INT_BITS + 3;
	localparam int SB        = SAMPLE_BITS;
	localparam int ST        = stp_pkg::STAGE_BITS;
	localparam int OB        = stp_pkg::OPND_BITS;
	localparam int CB        = stp_pkg::CHUNK_BITS;
	localparam int YW        = ST + 2;

	localparam logic [GF-1:0] G_MIN = GF'((2 ** GF) / 100);
	localparam logic [GF-1:0] G_MAX = GF'(((2 ** GF) * 99) / 100);
	localparam logic signed [ST-1:0] ST_MAX = {1'b0, {(ST-1){1'b1}}};
	localparam logic signed [ST-1:0] ST_MIN = {1'b1, {(ST-1){1'b0}}};
	localparam logic signed [SB-1:0] Y_MAX  = {1'b0, {(SB-1){1'b1}}};
	localparam logic signed [SB-1:0] Y_MIN  = {1'b1, {(SB-1){1'b0}}};

	typedef enum logic [4:0] {
		S_IDLE, S_DIFF, S_FD_LO, S_FD_HI, S_FD_END, S_INNER,
		S_A0, S_A1, S_A2, S_A3, S_A_END, S_ST1,
		S_B0, S_B1, S_B2, S_B3, S_B_END, S_ST2, S_DONE
	} state_t;

	state_t state_q;
	logic   ch_q;
	logic   out_vld_q;

	// configuration
	logic          mode_q;
	logic [GF-1:0] gain_q [2];
	logic [FB_BITS-1:0] fb_q [2];

	// filter state, per channel
	logic signed [ST-1:0] st1_q [2];
	logic signed [ST-1:0] st2_q [2];

	// per-item working registers
	logic signed [SB-1:0] x_q [2];
	logic [GF-1:0]        g_q;
	logic [GF-1:0]        h_q;
	logic [FB_BITS-1:0]   f_q;
	logic signed [OB-1:0] opnd_q;
	logic signed [SB-1:0] yl_q;
	logic signed [SB-1:0] yr_q;
	logic signed [SB-1:0] left_out_q;
	logic signed [SB-1:0] right_out_q;

	// datapath
	stp_pkg::mac_ctrl_t          mac_ctrl;
	logic [COEF_BITS-1:0]        coef;
	logic signed [OB-1:0]        src_val;
	logic signed [CB:0]          chunk;
	logic signed [ACC_BITS-1:0]  acc;
	logic signed [ACC_BITS-1:0]  acc_sh;
	logic signed [ST-1:0]        st_sat;
	logic [GF-1:0]               gain_sel;
	logic [GF-1:0]               g_clamp;
	logic signed [SB+stp_pkg::STATE_FRAC_BITS-1:0] xs;
	logic signed [YW-1:0]        y_base;
	logic signed [YW-1:0]        y_pre;
	logic signed [SB-1:0]        y_sat;
	logic                        in_acc;
	logic                        out_load;

	assign in_acc   = samples.valid && samples.ready;
	assign out_load = (state_q == S_DONE) && (!out_vld_q || filtered.ready);

	// coefficient and operand selection per sequencer step
	always_comb begin
		mac_ctrl = '0;
		coef     = COEF_BITS'(f_q);
		src_val  = opnd_q;
		unique case (state_q)
			S_DIFF, S_INNER, S_ST1, S_ST2: mac_ctrl.clear = 1'b1;
			S_FD_LO: mac_ctrl.issue = 1'b1;
			S_FD_HI: begin
				mac_ctrl.issue = 1'b1;
				mac_ctrl.hi    = 1'b1;
			end
			S_A0, S_A1: begin
				mac_ctrl.issue = 1'b1;
				mac_ctrl.hi    = (state_q == S_A1);
				coef           = COEF_BITS'(h_q);
				src_val        = OB'(st1_q[ch_q]);
			end
			S_A2, S_A3: begin
				mac_ctrl.issue = 1'b1;
				mac_ctrl.hi    = (state_q == S_A3);
				coef           = COEF_BITS'(g_q);
			end
			S_B0, S_B1: begin
				mac_ctrl.issue = 1'b1;
				mac_ctrl.hi    = (state_q == S_B1);
				coef           = COEF_BITS'(h_q);
				src_val        = OB'(st2_q[ch_q]);
			end
			S_B2, S_B3: begin
				mac_ctrl.issue = 1'b1;
				mac_ctrl.hi    = (state_q == S_B3);
				coef           = COEF_BITS'(g_q);
				src_val        = OB'(st1_q[ch_q]);
			end
			default: ;
		endcase
	end

	assign chunk = mac_ctrl.hi ? $signed({src_val[OB-1], src_val[OB-1:CB]})
	                           : $signed({1'b0, src_val[CB-1:0]});

	stp_mac #(
		.COEF_BITS (COEF_BITS),
		.ACC_BITS  (ACC_BITS)
	) u_mac (
		.clk    (clk),
		.arst_n (arst_n),
		.ctrl   (mac_ctrl),
		.coef   (coef),
		.chunk  (chunk),
		.acc    (acc)
	);

	// floor shift and saturate the finished sum
	assign acc_sh = acc >>> GF;
	always_comb begin
		if ((&acc_sh[ACC_BITS-1:ST-1]) || !(|acc_sh[ACC_BITS-1:ST-1])) begin
			st_sat = acc_sh[ST-1:0];
		end else begin
			st_sat = acc_sh[ACC_BITS-1] ? ST_MIN : ST_MAX;
		end
	end

	assign gain_sel = gain_q[ch_q];
	assign g_clamp  = (gain_sel < G_MIN) ? G_MIN : ((gain_sel > G_MAX) ? G_MAX : gain_sel);
	assign xs       = {x_q[ch_q], {stp_pkg::STATE_FRAC_BITS{1'b0}}};

	// channel output from the new stage two value
	assign y_base = YW'(st_sat >>> stp_pkg::STATE_FRAC_BITS);
	assign y_pre  = mode_q ? (YW'(x_q[ch_q]) - y_base) : y_base;
	always_comb begin
		if ((&y_pre[YW-1:SB-1]) || !(|y_pre[YW-1:SB-1])) begin
			y_sat = y_pre[SB-1:0];
		end else begin
			y_sat = y_pre[YW-1] ? Y_MIN : Y_MAX;
		end
	end

	// sequencer, configuration and filter state
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q   <= S_IDLE;
			ch_q      <= 1'b0;
			out_vld_q <= 1'b0;
			mode_q    <= 1'b0;
			gain_q[0] <= G_MAX;
			gain_q[1] <= G_MAX;
			fb_q[0]   <= '0;
			fb_q[1]   <= '0;
			st1_q[0]  <= '0;
			st1_q[1]  <= '0;
			st2_q[0]  <= '0;
			st2_q[1]  <= '0;
		end else begin
			if (cfg_wr_en) begin
				unique case (cfg_index)
					stp_pkg::REG_MODE:       mode_q    <= cfg_data[0];
					stp_pkg::REG_LEFT_GAIN:  gain_q[0] <= cfg_data[GF-1:0];
					stp_pkg::REG_RIGHT_GAIN: gain_q[1] <= cfg_data[GF-1:0];
					stp_pkg::REG_LEFT_FB:    fb_q[0]   <= cfg_data[FB_BITS-1:0];
					stp_pkg::REG_RIGHT_FB:   fb_q[1]   <= cfg_data[FB_BITS-1:0];
					default: ;
				endcase
			end

			if (out_load) begin
				out_vld_q <= 1'b1;
			end else if (filtered.valid && filtered.ready) begin
				out_vld_q <= 1'b0;
			end

			unique case (state_q)
				S_IDLE: begin
					if (in_acc) begin
						ch_q    <= 1'b0;
						state_q <= S_DIFF;
					end
				end
				S_DIFF:   state_q <= S_FD_LO;
				S_FD_LO:  state_q <= S_FD_HI;
				S_FD_HI:  state_q <= S_FD_END;
				S_FD_END: state_q <= S_INNER;
				S_INNER:  state_q <= S_A0;
				S_A0:     state_q <= S_A1;
				S_A1:     state_q <= S_A2;
				S_A2:     state_q <= S_A3;
				S_A3:     state_q <= S_A_END;
				S_A_END:  state_q <= S_ST1;
				S_ST1: begin
					st1_q[ch_q] <= st_sat;
					state_q     <= S_B0;
				end
				S_B0:     state_q <= S_B1;
				S_B1:     state_q <= S_B2;
				S_B2:     state_q <= S_B3;
				S_B3:     state_q <= S_B_END;
				S_B_END:  state_q <= S_ST2;
				S_ST2: begin
					st2_q[ch_q] <= st_sat;
					if (!ch_q) begin
						ch_q    <= 1'b1;
						state_q <= S_DIFF;
					end else begin
						state_q <= S_DONE;
					end
				end
				S_DONE: begin
					// hold until the output register is free
					if (out_load) begin
						state_q <= S_IDLE;
					end
				end
				default: state_q <= S_IDLE;
			endcase
		end
	end

	// per-item working data
	always_ff @(posedge clk) begin
		if (in_acc) begin
			x_q[0] <= samples.left_sample;
			x_q[1] <= samples.right_sample;
		end
		if (state_q == S_DIFF) begin
			g_q    <= g_clamp;
			h_q    <= GF'({1'b1, {GF{1'b0}}} - {1'b0, g_clamp});
			f_q    <= fb_q[ch_q];
			opnd_q <= OB'(st1_q[ch_q]) - OB'(st2_q[ch_q]);
		end
		if (state_q == S_INNER) begin
			opnd_q <= acc_sh[OB-1:0] + OB'(xs);
		end
		if (state_q == S_ST2 && !ch_q) begin
			yl_q <= y_sat;
		end
		if (state_q == S_ST2 && ch_q) begin
			yr_q <= y_sat;
		end
		// hold the output pair until the previous one has left
		if (out_load) begin
			left_out_q  <= yl_q;
			right_out_q <= yr_q;
		end
	end

	assign samples.ready      = (state_q == S_IDLE);
	assign filtered.valid     = out_vld_q;
	assign filtered.left_out  = left_out_q;
	assign filtered.right_out = right_out_q;

	// ------------------------------------------------------------------
	// assertions
	// ------------------------------------------------------------------
	a_accept_starts_left: assert property (@(posedge clk) disable iff (!arst_n)
		in_acc |=> (state_q == S_DIFF && ch_q == 1'b0))
		else $error("accepted request did not start the left channel");

	a_result_from_done: assert property (@(posedge clk) disable iff (!arst_n)
		$rose(out_vld_q) |-> $past(state_q == S_DONE))
		else $error("result raised outside the done step");

	a_gain_clamped: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == S_FD_LO) |-> (g_q >= G_MIN && g_q <= G_MAX
			&& (GF + 1)'(g_q) + (GF + 1)'(h_q) == (GF + 1)'(2 ** GF)))
		else $error("working gain out of range or complement wrong");

	a_state_held_idle: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == S_IDLE && $past(state_q == S_IDLE))
			|-> ($stable(st1_q[0]) && $stable(st2_q[0]) && $stable(st1_q[1])
				&& $stable(st2_q[1])))
		else $error("filter state changed while idle");
endmodule

// ===== rtl/stp_mac.sv =====
// ----------------------------------------------------------------------------
// stp_mac
// Shared multiply-accumulate unit: unsigned coefficient times a signed chunk,
// product registered, then added into the accumulator at chunk weight.
// ----------------------------------------------------------------------------
module stp_mac #(
	parameter int COEF_BITS = stp_pkg::GAIN_FRAC_BITS_DEF + stp_pkg::FB_INT_BITS,
	parameter int ACC_BITS  = stp_pkg::GAIN_FRAC_BITS_DEF + stp_pkg::STAGE_BITS
		+ stp_pkg::FB_INT_BITS + 3
) (
	input  logic                                 clk,
	input  logic                                 arst_n,
	input  stp_pkg::mac_ctrl_t                   ctrl,
	input  logic [COEF_BITS-1:0]                 coef,
	input  logic signed [stp_pkg::CHUNK_BITS:0]  chunk,
	output logic signed [ACC_BITS-1:0]           acc
);
	localparam int PROD_BITS = COEF_BITS + stp_pkg::CHUNK_BITS + 2;

	logic signed [PROD_BITS-1:0] prod_s1;
	logic                        vld_s1;
	logic                        hi_s1;
	logic signed [ACC_BITS-1:0]  acc_q;
	logic signed [ACC_BITS-1:0]  addend;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_s1 <= 1'b0;
			hi_s1  <= 1'b0;
		end else begin
			vld_s1 <= ctrl.issue;
			hi_s1  <= ctrl.hi;
		end
	end

	assign addend = hi_s1 ? (ACC_BITS'(prod_s1) <<< stp_pkg::CHUNK_BITS) : ACC_BITS'(prod_s1);

	always_ff @(posedge clk) begin
		prod_s1 <= $signed({1'b0, coef}) * chunk;
		if (ctrl.clear) begin
			acc_q <= '0;
		end else if (vld_s1) begin
			acc_q <= acc_q + addend;
		end
	end

	assign acc = acc_q;
endmodule

// ===== dv/stereo_filter_checker.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// stereo_filter_checker
// Watches the configuration port and both stereo channels of the filter,
// tracks the register settings and per-channel stage values, predicts each
// filtered pair, and compares it field by field with what the block returns.
// ----------------------------------------------------------------------------
module stereo_filter_checker (
	input  logic                                                    clk,
	input  logic                                                    arst_n,
	input  logic                                                    cfg_wr_en,
	input  logic [stp_pkg::CFG_IDX_BITS-1:0]                        cfg_index,
	input  logic [stp_pkg::GAIN_FRAC_BITS_DEF+stp_pkg::FB_INT_BITS-1:0] cfg_data,
	stp_in_if                                                       samples,
	stp_out_if                                                      filtered,
	output int                                                      mismatch_count,
	output int                                                      pending_count
);
	import stp_pkg::*;

	localparam int SB  = SAMPLE_BITS_DEF;
	localparam int GF  = GAIN_FRAC_BITS_DEF;
	localparam int FBW = GAIN_FRAC_BITS_DEF + FB_INT_BITS;

	localparam longint UNITY      = longint'(1) <<< GF;
	localparam longint GAIN_FLOOR = UNITY / 100;
	localparam longint GAIN_CEIL  = (UNITY * 99) / 100;

	typedef struct packed {
		logic signed [SB-1:0] left_out;
		logic signed [SB-1:0] right_out;
	} filtered_pair_t;

	logic           highpass;
	logic [GF-1:0]  left_gain;
	logic [GF-1:0]  right_gain;
	logic [FBW-1:0] left_fb;
	logic [FBW-1:0] right_fb;

	// left stage one, left stage two, right stage one, right stage two
	longint stage_val [4];

	filtered_pair_t expected_pairs [$];

	function automatic longint clip(input longint v, input int bits);
		longint top;
		top = (longint'(1) <<< (bits - 1)) - 1;
		if (v > top)
			return top;
		if (v < -top - 1)
			return -top - 1;
		return v;
	endfunction

	// Advance one channel's two stages and return its output sample.
	function automatic logic signed [SB-1:0] filter_channel(input int base,
			input logic signed [SB-1:0] x, input logic [GF-1:0] gain_reg,
			input logic [FBW-1:0] fb_reg);
		longint g;
		longint h;
		longint f;
		longint xs;
		longint inner;
		longint acc;
		longint y;
		g = gain_reg;
		if (g < GAIN_FLOOR)
			g = GAIN_FLOOR;
		if (g > GAIN_CEIL)
			g = GAIN_CEIL;
		h = UNITY - g;
		f = fb_reg;
		xs = longint'(x) <<< STATE_FRAC_BITS;

		inner = xs + ((f * (stage_val[base] - stage_val[base+1])) >>> GF);
		acc = h * stage_val[base] + g * inner;
		stage_val[base] = clip(acc >>> GF, STAGE_BITS);

		acc = h * stage_val[base+1] + g * stage_val[base];
		stage_val[base+1] = clip(acc >>> GF, STAGE_BITS);

		y = stage_val[base+1] >>> STATE_FRAC_BITS;
		if (highpass)
			y = longint'(x) - y;
		y = clip(y, SB);
		return y[SB-1:0];
	endfunction

	always @(posedge clk or negedge arst_n) begin
		filtered_pair_t want;
		if (!arst_n) begin
			highpass = 1'b0;
			left_gain = GF'(GAIN_CEIL);
			right_gain = GF'(GAIN_CEIL);
			left_fb = '0;
			right_fb = '0;
			foreach (stage_val[i])
				stage_val[i] = 0;
			expected_pairs.delete();
			mismatch_count = 0;
			pending_count = 0;
		end else begin
			if (cfg_wr_en) begin
				case (cfg_index)
					REG_MODE:       highpass = cfg_data[0];
					REG_LEFT_GAIN:  left_gain = cfg_data[GF-1:0];
					REG_RIGHT_GAIN: right_gain = cfg_data[GF-1:0];
					REG_LEFT_FB:    left_fb = cfg_data;
					REG_RIGHT_FB:   right_fb = cfg_data;
					default: ;
				endcase
			end

			// compare before queuing, so a stray result never meets a fresh request
			if (filtered.valid && filtered.ready) begin
				if (expected_pairs.size() == 0) begin
					mismatch_count++;
					$error("filtered pair with no request pending: left_out %0d right_out %0d",
						filtered.left_out, filtered.right_out);
				end else begin
					want = expected_pairs.pop_front();
					if (filtered.left_out !== want.left_out) begin
						mismatch_count++;
						$error("left_out: expected %0d, got %0d", want.left_out,
							filtered.left_out);
					end
					if (filtered.right_out !== want.right_out) begin
						mismatch_count++;
						$error("right_out: expected %0d, got %0d", want.right_out,
							filtered.right_out);
					end
				end
			end

			if (samples.valid && samples.ready) begin
				want.left_out = filter_channel(0, samples.left_sample, left_gain, left_fb);
				want.right_out = filter_channel(2, samples.right_sample, right_gain, right_fb);
				expected_pairs.push_back(want);
			end

			pending_count = expected_pairs.size();
		end
	end

endmodule

// ===== dv/testbench.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// testbench
// Stimulus and verdict for the stereo two-pole resonant filter. Writes a
// series of register settings between quiet phases, sends directed extreme
// sample pairs and then random pairs with random gaps and output stalls.
// ----------------------------------------------------------------------------
module testbench;
	import stp_pkg::*;

	localparam int SB  = SAMPLE_BITS_DEF;
	localparam int FBW = GAIN_FRAC_BITS_DEF + FB_INT_BITS;

	localparam int             STALL_LIMIT     = 3000;
	localparam int             SETTLE_CYCLES   = 40;
	localparam int             HOLD_OFF_CYCLES = 400;
	localparam int             RANDOM_PHASES   = 22;
	localparam int             PHASE_PAIRS     = 65;
	localparam logic [FBW-1:0] FB_TOP          = 23'd6619136;
	localparam logic [FBW-1:0] FB_ALL_ONES     = '1;
	localparam logic [CFG_IDX_BITS-1:0] REG_LAST_INDEX = '1;

	logic                       clk = 1'b0;
	logic                       arst_n;
	logic                       cfg_wr_en;
	logic [CFG_IDX_BITS-1:0]    cfg_index;
	logic [FBW-1:0]             cfg_data;
	int                         mismatch_count;
	int                         pending_count;

	bit steady_flow = 1'b0;
	bit hold_off_req = 1'b0;

	// square-wave content shared across requests
	bit square_high = 1'b0;
	int square_left = 0;
	int square_amp = 0;

	stp_in_if  samples_ch ();
	stp_out_if filtered_ch ();

	stereo_two_pole_resonant_filter_unit dut (
		.clk       (clk),
		.arst_n    (arst_n),
		.cfg_wr_en (cfg_wr_en),
		.cfg_index (cfg_index),
		.cfg_data  (cfg_data),
		.samples   (samples_ch),
		.filtered  (filtered_ch)
	);

	stereo_filter_checker filter_check (
		.clk            (clk),
		.arst_n         (arst_n),
		.cfg_wr_en      (cfg_wr_en),
		.cfg_index      (cfg_index),
		.cfg_data       (cfg_data),
		.samples        (samples_ch),
		.filtered       (filtered_ch),
		.mismatch_count (mismatch_count),
		.pending_count  (pending_count)
	);

	always #6 clk = ~clk;

	task automatic push_pair(input logic signed [SB-1:0] l, input logic signed [SB-1:0] r);
		while (!steady_flow && $urandom_range(0, 99) < 10) begin
			samples_ch.valid <= 1'b0;
			@(negedge clk);
		end
		samples_ch.valid <= 1'b1;
		samples_ch.left_sample <= l;
		samples_ch.right_sample <= r;
		do
			@(posedge clk);
		while (!samples_ch.ready);
		@(negedge clk);
	endtask

	// Drop valid and wait until every request has come back.
	task automatic drain();
		samples_ch.valid <= 1'b0;
		while (pending_count != 0)
			@(negedge clk);
		repeat (SETTLE_CYCLES) @(negedge clk);
	endtask

	// Leaves the write enable high; the caller lowers it after the last write.
	task automatic write_reg(input logic [CFG_IDX_BITS-1:0] idx, input logic [FBW-1:0] value);
		cfg_wr_en <= 1'b1;
		cfg_index <= idx;
		cfg_data <= value;
		@(negedge clk);
	endtask

	function automatic logic [FBW-1:0] pick_gain();
		case ($urandom_range(0, 4))
			0: begin
				case ($urandom_range(0, 7))
					0: return 23'd0;
					1: return 23'd654;
					2: return 23'd655;
					3: return 23'd656;
					4: return 23'd64879;
					5: return 23'd64880;
					6: return 23'd64881;
					default: return 23'd65535;
				endcase
			end
			1: return FBW'($urandom_range(0, 65535));
			2: return FBW'($urandom_range(655, 64880));
			3: return FBW'($urandom);
			default: return FBW'($urandom_range(655, 4000));
		endcase
	endfunction

	function automatic logic [FBW-1:0] pick_feedback();
		case ($urandom_range(0, 4))
			0: return '0;
			1: return FB_TOP;
			2: return FB_ALL_ONES;
			3: return FBW'($urandom_range(0, 65536));
			default: return FBW'($urandom);
		endcase
	endfunction

	task automatic shuffle_settings(input bit every_reg);
		bit wrote;
		wrote = 1'b0;
		if (every_reg || $urandom_range(0, 9) < 7) begin
			write_reg(REG_MODE, FBW'($urandom));
			wrote = 1'b1;
		end
		if (every_reg || $urandom_range(0, 9) < 7) begin
			write_reg(REG_LEFT_GAIN, pick_gain());
			wrote = 1'b1;
		end
		if (every_reg || $urandom_range(0, 9) < 7) begin
			write_reg(REG_RIGHT_GAIN, pick_gain());
			wrote = 1'b1;
		end
		if (every_reg || $urandom_range(0, 9) < 7) begin
			write_reg(REG_LEFT_FB, pick_feedback());
			wrote = 1'b1;
		end
		if (every_reg || $urandom_range(0, 9) < 7) begin
			write_reg(REG_RIGHT_FB, pick_feedback());
			wrote = 1'b1;
		end
		if ($urandom_range(0, 9) < 3) begin
			write_reg(CFG_IDX_BITS'($urandom_range(REG_RIGHT_FB + 1, REG_LAST_INDEX)),
				FBW'($urandom));
			wrote = 1'b1;
		end
		if (wrote)
			cfg_wr_en <= 1'b0;
	endtask

	function automatic logic signed [SB-1:0] edge_sample();
		case ($urandom_range(0, 4))
			0: return 16'sh7FFF;
			1: return 16'sh8000;
			2: return 16'sh0000;
			3: return 16'shFFFF;
			default: return 16'sh0001;
		endcase
	endfunction

	task automatic next_pair(output logic signed [SB-1:0] l, output logic signed [SB-1:0] r);
		int pick;
		pick = $urandom_range(0, 99);
		if (pick < 45) begin
			l = SB'($urandom);
			r = SB'($urandom);
		end else if (pick < 65) begin
			l = edge_sample();
			r = edge_sample();
		end else if (pick < 85) begin
			// flip the square wave after a random run of requests
			if (square_left == 0) begin
				square_high = !square_high;
				square_left = $urandom_range(1, 12);
				square_amp = $urandom_range(0, 32767);
			end
			square_left--;
			l = square_high ? square_amp[SB-1:0] : ~square_amp[SB-1:0];
			r = square_high ? ~square_amp[SB-1:0] : square_amp[SB-1:0];
		end else begin
			l = SB'(int'($urandom_range(0, 128)) - 64);
			r = SB'(int'($urandom_range(0, 128)) - 64);
		end
	endtask

	// receiver: random back-pressure, plus one long hold-off on request
	initial begin
		filtered_ch.ready = 1'b0;
		forever begin
			@(negedge clk);
			if (hold_off_req) begin
				hold_off_req = 1'b0;
				filtered_ch.ready <= 1'b0;
				repeat (HOLD_OFF_CYCLES) @(negedge clk);
			end else begin
				filtered_ch.ready <= steady_flow || ($urandom_range(0, 99) >= 10);
			end
		end
	end

	initial begin
		int quiet;
		quiet = 0;
		while (quiet < STALL_LIMIT) begin
			@(posedge clk);
			if ((samples_ch.valid && samples_ch.ready) ||
					(filtered_ch.valid && filtered_ch.ready))
				quiet = 0;
			else
				quiet++;
		end
		$display("SCOREBOARD MISMATCH");
		$finish;
	end

	initial begin
		logic signed [SB-1:0] l;
		logic signed [SB-1:0] r;
		arst_n = 1'b0;
		cfg_wr_en = 1'b0;
		cfg_index = '0;
		cfg_data = '0;
		samples_ch.valid = 1'b0;
		samples_ch.left_sample = '0;
		samples_ch.right_sample = '0;
		repeat (11) @(negedge clk);
		arst_n <= 1'b1;
		@(negedge clk);

		// reset settings: zero, full-scale steps of both signs
		push_pair(16'sh0000, 16'sh0000);
		repeat (3) push_pair(16'sh7FFF, 16'sh8000);
		repeat (2) push_pair(16'sh8000, 16'sh7FFF);
		push_pair(16'shFFFF, 16'sh0001);
		drain();

		// high-pass, gains below and above the clamp, large and largest feedback: drive overflow
		write_reg(REG_MODE, 23'd1);
		write_reg(REG_LEFT_GAIN, 23'd0);
		write_reg(REG_RIGHT_GAIN, 23'd65535);
		write_reg(REG_LEFT_FB, FB_TOP);
		write_reg(REG_RIGHT_FB, FB_ALL_ONES);
		cfg_wr_en <= 1'b0;
		for (int k = 0; k < 8; k++) begin
			if (k % 2 == 0)
				push_pair(16'sh7FFF, 16'sh8000);
			else
				push_pair(16'sh8000, 16'sh7FFF);
		end
		drain();

		// masked register bits and a write to an unknown index
		write_reg(REG_MODE, 23'h000002);
		write_reg(REG_LEFT_GAIN, 23'h7F028F);
		write_reg(REG_RIGHT_GAIN, 23'd654);
		write_reg(REG_LAST_INDEX, FB_ALL_ONES);
		cfg_wr_en <= 1'b0;
		repeat (4) push_pair(16'sh7FFF, 16'sh7FFF);
		repeat (4) push_pair(16'sh8000, 16'sh8000);

		for (int phase = 0; phase < RANDOM_PHASES; phase++) begin
			drain();
			shuffle_settings(phase == 0);
			steady_flow = (phase == 9);
			if (phase == 4)
				hold_off_req = 1'b1;
			repeat (PHASE_PAIRS) begin
				next_pair(l, r);
				push_pair(l, r);
			end
		end
		steady_flow = 1'b0;
		drain();

		if (mismatch_count == 0 && pending_count == 0)
			$display("SCOREBOARD CLEAN");
		else
			$display("SCOREBOARD MISMATCH");
		$finish;
	end

endmodule
